/* design/mqrp_pkg.sv */
package mqrp_pkg;

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;
  localparam logic [1:0] KIND_DECAY  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_TOUCHED  = 3'd1;
  localparam logic [2:0] ST_PROMOTED = 3'd2;
  localparam logic [2:0] ST_RESTORED = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_POPPED   = 3'd5;
  localparam logic [2:0] ST_HEMPTY   = 3'd6;
  localparam logic [2:0] ST_DECAYED  = 3'd7;

  // Level code reported for an entry that sits in history
  localparam logic [2:0] LVL_HIST = 3'b111;

  // Configuration register indexes
  localparam logic [1:0] CFG_INSERT_LEVEL = 2'd0;
  localparam logic [1:0] CFG_HEAT_STEP    = 2'd1;
  localparam logic [1:0] CFG_PROMOTE_THR  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEARCH,
    CMD_MISS,
    CMD_NEW,
    CMD_REMOVE,
    CMD_EVAL,
    CMD_DROP,
    CMD_DEMOTE,
    CMD_PUSH,
    CMD_POP,
    CMD_EMPTY,
    CMD_DECAY
  } mqrp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_EVAL,
    S_PLACE,
    S_DROP,
    S_DEMOTE,
    S_PUSH,
    S_POP,
    S_DECAY,
    S_DONE
  } mqrp_state_e;

  typedef struct packed {
    logic found;
    logic found_hist;
    logic tq_full;
    logic hist_full;
    logic hist_empty;
    logic [1:0] kind;
  } mqrp_stat_t;

endpackage

/* design/mqrp_ctrl.sv */
module mqrp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [1:0]             kind_i,
  input  mqrp_pkg::mqrp_stat_t   stat_i,
  output mqrp_pkg::mqrp_cmd_e    cmd_o,
  output logic                   busy,
  output logic                   result_valid_o
);

  mqrp_pkg::mqrp_state_e state_q, state_d;
  logic accept;

  assign accept = start && (state_q == mqrp_pkg::S_IDLE);

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqrp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mqrp_pkg::S_IDLE: begin
        if (accept) begin
          case (kind_i)
            mqrp_pkg::KIND_POP:   state_d = mqrp_pkg::S_POP;
            mqrp_pkg::KIND_DECAY: state_d = mqrp_pkg::S_DECAY;
            default:              state_d = mqrp_pkg::S_SEARCH;
          endcase
        end
      end
      mqrp_pkg::S_SEARCH: state_d = mqrp_pkg::S_DECIDE;
      mqrp_pkg::S_DECIDE: begin
        if (stat_i.found) begin
          state_d = mqrp_pkg::S_EVAL;
        end else if (stat_i.kind == mqrp_pkg::KIND_LOOKUP) begin
          state_d = mqrp_pkg::S_DONE;
        end else begin
          state_d = mqrp_pkg::S_PLACE;
        end
      end
      mqrp_pkg::S_EVAL: state_d = mqrp_pkg::S_PLACE;
      mqrp_pkg::S_PLACE: begin
        if (!stat_i.tq_full) begin
          state_d = mqrp_pkg::S_PUSH;
        end else if (stat_i.hist_full) begin
          state_d = mqrp_pkg::S_DROP;
        end else begin
          state_d = mqrp_pkg::S_DEMOTE;
        end
      end
      mqrp_pkg::S_DROP:   state_d = mqrp_pkg::S_DEMOTE;
      mqrp_pkg::S_DEMOTE: state_d = mqrp_pkg::S_PUSH;
      mqrp_pkg::S_PUSH:   state_d = mqrp_pkg::S_DONE;
      mqrp_pkg::S_POP:    state_d = mqrp_pkg::S_DONE;
      mqrp_pkg::S_DECAY:  state_d = mqrp_pkg::S_DONE;
      mqrp_pkg::S_DONE:   state_d = mqrp_pkg::S_IDLE;
      default:            state_d = mqrp_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and handshake outputs
  always_comb begin
    cmd_o          = mqrp_pkg::CMD_NONE;
    busy           = (state_q != mqrp_pkg::S_IDLE);
    result_valid_o = 1'b0;
    case (state_q)
      mqrp_pkg::S_IDLE: begin
        if (accept) cmd_o = mqrp_pkg::CMD_LOAD;
      end
      mqrp_pkg::S_SEARCH: cmd_o = mqrp_pkg::CMD_SEARCH;
      mqrp_pkg::S_DECIDE: begin
        if (stat_i.found) begin
          cmd_o = mqrp_pkg::CMD_REMOVE;
        end else if (stat_i.kind == mqrp_pkg::KIND_LOOKUP) begin
          cmd_o = mqrp_pkg::CMD_MISS;
        end else begin
          cmd_o = mqrp_pkg::CMD_NEW;
        end
      end
      mqrp_pkg::S_EVAL:   cmd_o = mqrp_pkg::CMD_EVAL;
      mqrp_pkg::S_DROP:   cmd_o = mqrp_pkg::CMD_DROP;
      mqrp_pkg::S_DEMOTE: cmd_o = mqrp_pkg::CMD_DEMOTE;
      mqrp_pkg::S_PUSH:   cmd_o = mqrp_pkg::CMD_PUSH;
      mqrp_pkg::S_POP: begin
        cmd_o = stat_i.hist_empty ? mqrp_pkg::CMD_EMPTY : mqrp_pkg::CMD_POP;
      end
      mqrp_pkg::S_DECAY:  cmd_o = mqrp_pkg::CMD_DECAY;
      mqrp_pkg::S_DONE:   result_valid_o = 1'b1;
      default:            cmd_o = mqrp_pkg::CMD_NONE;
    endcase
  end

  // A transfer always moves the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("accepted request did not raise busy");

  // The result strobe lasts one cycle and frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("result strobe not followed by idle");

  // The strobe only fires while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy)
    else $error("result strobe outside a request");

endmodule

/* design/mqrp_datapath.sv */
module mqrp_datapath #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 8,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mqrp_pkg::mqrp_cmd_e    cmd_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic [1:0]             kind_i,
  input  logic [KEY_BITS-1:0]    req_key_i,
  input  logic [VALUE_BITS-1:0]  req_value_i,
  output mqrp_pkg::mqrp_stat_t   stat_o,
  output logic [2:0]             status_o,
  output logic signed [2:0]      out_level_o,
  output logic [KEY_BITS-1:0]    out_key_o,
  output logic [VALUE_BITS-1:0]  out_value_o,
  output logic                   dropped_valid_o,
  output logic [KEY_BITS-1:0]    dropped_key_o
);

  localparam int NQ = LEVELS + 1;
  localparam int HQ = LEVELS;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = $clog2(NQ);
  localparam int LW = $clog2(LEVELS);
  localparam logic [QW-1:0] HQ_IDX = QW'(HQ);
  localparam logic [FW-1:0] FULL   = FW'(QUEUE_DEPTH);

  // Queue storage: queue q, position p counted from the oldest entry
  logic [KEY_BITS-1:0]   key_q  [NQ][QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] val_q  [NQ][QUEUE_DEPTH];
  logic [7:0]            heat_q [NQ][QUEUE_DEPTH];
  logic [LW-1:0]         org_q  [NQ][QUEUE_DEPTH];
  logic [FW-1:0]         fill_q [NQ];
  logic [FW-1:0]         fill_d [NQ];

  // Configuration
  logic [1:0] ins_q;
  logic [7:0] step_q;
  logic [7:0] thr_q;

  // Request and working entry
  logic [1:0]            kind_q;
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic                  found_q;
  logic [QW-1:0]         fq_q;
  logic [PW-1:0]         fpos_q;
  logic [KEY_BITS-1:0]   e_key_q;
  logic [VALUE_BITS-1:0] e_val_q;
  logic [7:0]            e_heat_q;
  logic [LW-1:0]         e_org_q;
  logic [QW-1:0]         tq_q;

  // Result
  logic [2:0]            status_q;
  logic [2:0]            level_q;
  logic [KEY_BITS-1:0]   okey_q;
  logic [VALUE_BITS-1:0] oval_q;
  logic                  dv_q;
  logic [KEY_BITS-1:0]   dk_q;

  // Key match over all valid entries, lowest queue and position wins
  logic          hit_any;
  logic [QW-1:0] hit_q;
  logic [PW-1:0] hit_pos;

  always_comb begin
    hit_any = 1'b0;
    hit_q   = '0;
    hit_pos = '0;
    for (int q = NQ - 1; q >= 0; q--) begin
      for (int p = QUEUE_DEPTH - 1; p >= 0; p--) begin
        if ((FW'(p) < fill_q[q]) && (key_q[q][p] == rkey_q)) begin
          hit_any = 1'b1;
          hit_q   = QW'(q);
          hit_pos = PW'(p);
        end
      end
    end
  end

  // Heat update and promotion decision for the working entry
  logic [8:0]    heat_sum;
  logic [7:0]    heat_new;
  logic [QW-1:0] base_q;
  logic          promote;

  assign heat_sum = {1'b0, e_heat_q} + {1'b0, step_q};
  assign heat_new = heat_sum[8] ? 8'hFF : heat_sum[7:0];
  assign base_q   = (fq_q == HQ_IDX) ? QW'(e_org_q) : fq_q;
  assign promote  = ((32'(base_q) + 1) < LEVELS) && (heat_new >= thr_q);

  logic [QW-1:0] ins_lvl;
  assign ins_lvl = (32'(ins_q) >= LEVELS) ? QW'(LEVELS - 1) : QW'(ins_q);

  // Shift and push controls
  logic                  sh_en;
  logic [QW-1:0]         sh_q;
  logic [PW-1:0]         sh_pos;
  logic                  pu_en;
  logic [QW-1:0]         pu_q;
  logic [PW-1:0]         pu_pos;
  logic [KEY_BITS-1:0]   pu_key;
  logic [VALUE_BITS-1:0] pu_val;
  logic [7:0]            pu_heat;
  logic [LW-1:0]         pu_org;
  logic                  decay;

  always_comb begin
    sh_en   = 1'b0;
    sh_q    = fq_q;
    sh_pos  = fpos_q;
    pu_en   = 1'b0;
    pu_q    = tq_q;
    pu_pos  = fill_q[tq_q][PW-1:0];
    pu_key  = e_key_q;
    pu_val  = e_val_q;
    pu_heat = e_heat_q;
    pu_org  = e_org_q;
    decay   = (cmd_i == mqrp_pkg::CMD_DECAY);
    case (cmd_i)
      mqrp_pkg::CMD_REMOVE: sh_en = 1'b1;
      mqrp_pkg::CMD_DROP, mqrp_pkg::CMD_POP: begin
        sh_en  = 1'b1;
        sh_q   = HQ_IDX;
        sh_pos = '0;
      end
      mqrp_pkg::CMD_DEMOTE: begin
        sh_en   = 1'b1;
        sh_q    = tq_q;
        sh_pos  = '0;
        pu_en   = 1'b1;
        pu_q    = HQ_IDX;
        pu_pos  = fill_q[HQ][PW-1:0];
        pu_key  = key_q[tq_q][0];
        pu_val  = val_q[tq_q][0];
        pu_heat = heat_q[tq_q][0];
        pu_org  = tq_q[LW-1:0];
      end
      mqrp_pkg::CMD_PUSH: pu_en = 1'b1;
      default: ;
    endcase
  end

  // Fill counts follow shifts, pushes and decay
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      fill_d[q] = fill_q[q];
      if (decay) begin
        if (q < LEVELS - 1) fill_d[q] = fill_q[q + 1];
        else if (q == LEVELS - 1) fill_d[q] = '0;
      end else begin
        if (sh_en && (sh_q == QW'(q))) fill_d[q] = fill_d[q] - FW'(1);
        if (pu_en && (pu_q == QW'(q))) fill_d[q] = fill_d[q] + FW'(1);
      end
    end
  end

  // Control state: fill counts and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NQ; q++) fill_q[q] <= '0;
      ins_q  <= 2'd0;
      step_q <= 8'd1;
      thr_q  <= 8'd2;
    end else begin
      for (int q = 0; q < NQ; q++) fill_q[q] <= fill_d[q];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mqrp_pkg::CFG_INSERT_LEVEL: ins_q  <= cfg_wdata_i[1:0];
          mqrp_pkg::CFG_HEAT_STEP:    step_q <= cfg_wdata_i;
          mqrp_pkg::CFG_PROMOTE_THR:  thr_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Queue entries: decay, shift toward the oldest end, push at the newest end
  always_ff @(posedge clk_i) begin
    for (int q = 0; q < NQ; q++) begin
      for (int p = 0; p < QUEUE_DEPTH; p++) begin
        if (decay) begin
          if (q < LEVELS - 1) begin
            key_q[q][p]  <= key_q[q + 1][p];
            val_q[q][p]  <= val_q[q + 1][p];
            heat_q[q][p] <= heat_q[q + 1][p];
            org_q[q][p]  <= org_q[q + 1][p];
          end
        end else if (sh_en && (sh_q == QW'(q)) && (PW'(p) >= sh_pos)
                     && (p + 1 < QUEUE_DEPTH)) begin
          key_q[q][p]  <= key_q[q][p + 1];
          val_q[q][p]  <= val_q[q][p + 1];
          heat_q[q][p] <= heat_q[q][p + 1];
          org_q[q][p]  <= org_q[q][p + 1];
        end
        if (pu_en && (pu_q == QW'(q)) && (pu_pos == PW'(p))) begin
          key_q[q][p]  <= pu_key;
          val_q[q][p]  <= pu_val;
          heat_q[q][p] <= pu_heat;
          org_q[q][p]  <= pu_org;
        end
      end
    end
  end

  // Request, working entry and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      mqrp_pkg::CMD_LOAD: begin
        kind_q   <= kind_i;
        rkey_q   <= req_key_i;
        rval_q   <= req_value_i;
        status_q <= mqrp_pkg::ST_DECAYED;
        level_q  <= '0;
        okey_q   <= '0;
        oval_q   <= '0;
        dv_q     <= 1'b0;
        dk_q     <= '0;
      end
      mqrp_pkg::CMD_SEARCH: begin
        found_q <= hit_any;
        fq_q    <= hit_q;
        fpos_q  <= hit_pos;
      end
      mqrp_pkg::CMD_MISS: status_q <= mqrp_pkg::ST_MISS;
      mqrp_pkg::CMD_NEW: begin
        e_key_q  <= rkey_q;
        e_val_q  <= rval_q;
        e_heat_q <= step_q;
        e_org_q  <= '0;
        tq_q     <= ins_lvl;
        status_q <= mqrp_pkg::ST_INSERTED;
        level_q  <= 3'(ins_lvl);
        oval_q   <= rval_q;
      end
      mqrp_pkg::CMD_REMOVE: begin
        e_key_q  <= key_q[fq_q][fpos_q];
        e_val_q  <= val_q[fq_q][fpos_q];
        e_heat_q <= heat_q[fq_q][fpos_q];
        e_org_q  <= org_q[fq_q][fpos_q];
      end
      mqrp_pkg::CMD_EVAL: begin
        e_heat_q <= promote ? step_q : heat_new;
        tq_q     <= promote ? base_q + QW'(1) : base_q;
        level_q  <= promote ? 3'(base_q + QW'(1)) : 3'(base_q);
        oval_q   <= e_val_q;
        if (fq_q == HQ_IDX) status_q <= mqrp_pkg::ST_RESTORED;
        else if (promote)   status_q <= mqrp_pkg::ST_PROMOTED;
        else                status_q <= mqrp_pkg::ST_TOUCHED;
      end
      mqrp_pkg::CMD_DROP: begin
        dv_q <= 1'b1;
        dk_q <= key_q[HQ][0];
      end
      mqrp_pkg::CMD_POP: begin
        status_q <= mqrp_pkg::ST_POPPED;
        level_q  <= mqrp_pkg::LVL_HIST;
        okey_q   <= key_q[HQ][0];
        oval_q   <= val_q[HQ][0];
      end
      mqrp_pkg::CMD_EMPTY: status_q <= mqrp_pkg::ST_HEMPTY;
      default: ;
    endcase
  end

  assign stat_o.found      = found_q;
  assign stat_o.found_hist = (fq_q == HQ_IDX);
  assign stat_o.tq_full    = (fill_q[tq_q] >= FULL);
  assign stat_o.hist_full  = (fill_q[HQ] >= FULL);
  assign stat_o.hist_empty = (fill_q[HQ] == '0);
  assign stat_o.kind       = kind_q;

  assign status_o        = status_q;
  assign out_level_o     = level_q;
  assign out_key_o       = okey_q;
  assign out_value_o     = oval_q;
  assign dropped_valid_o = dv_q;
  assign dropped_key_o   = dk_q;

  // Neither queue 0 nor the history queue ever holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[HQ] <= FULL) && (fill_q[0] <= FULL))
    else $error("queue fill exceeds depth");

  // A push never lands in a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pu_en |-> (fill_q[pu_q] < FULL))
    else $error("push into full queue");

  // A history drop only happens while the history queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == mqrp_pkg::CMD_DROP) |-> stat_o.hist_full)
    else $error("history drop while history not full");

endmodule

/* design/multi_queue_replacement_policy.sv */
// Channel   | Direction | Transfer condition
// ----------+-----------+------------------------------------------
// request   | in        | start high and busy low at a rising edge
// result    | out       | result_valid_o high for one cycle
// config    | in        | cfg_we_i high at a rising edge
//
// A lookup miss raises the result strobe after the key match and decision steps.
// An insert or a hit runs key match, decision, heat update on a hit, a placement
// check, then up to a history drop, a demotion and a push, one sequencer step each.
// Pop and decay each run their own step. Busy drops in the cycle after the strobe.
// Reset empties every queue at once through the fill counts.
// The receiver cannot stall; the result is shown for one cycle only.
module multi_queue_replacement_policy #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 8,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind_i,
  input  logic [KEY_BITS-1:0]    req_key_i,
  input  logic [VALUE_BITS-1:0]  req_value_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [7:0]             cfg_wdata_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic signed [2:0]      out_level_o,
  output logic [KEY_BITS-1:0]    out_key_o,
  output logic [VALUE_BITS-1:0]  out_value_o,
  output logic                   dropped_valid_o,
  output logic [KEY_BITS-1:0]    dropped_key_o
);

  mqrp_pkg::mqrp_cmd_e  cmd;
  mqrp_pkg::mqrp_stat_t stat;

  // Sequence the request steps
  mqrp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Hold the queues and execute each step
  mqrp_datapath #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .req_key_i       (req_key_i),
    .req_value_i     (req_value_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .out_level_o     (out_level_o),
    .out_key_o       (out_key_o),
    .out_value_o     (out_value_o),
    .dropped_valid_o (dropped_valid_o),
    .dropped_key_o   (dropped_key_o)
  );

endmodule
